@@ hdl/scp_pkg.sv @@
// Shared types and constants for the site pattern compressor.
// Used by the interfaces, controller, datapath, top level, checker and bench; no dependencies.
package scp_pkg;

    // Fixed field widths
    localparam int COL_W      = 64;
    localparam int CODE_W     = 4;
    localparam int LANES_MAX  = 16;
    localparam int CNT16_W    = 16;

    // Command codes on the input word
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    // Status codes on the result word
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [4:0]         NUM_TAXA_RESET = 5'd16;
    localparam logic [CNT16_W-1:0] SAT16          = 16'hFFFF;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_FINISH
    } state_t;

    // Read address source for the pattern memories
    typedef enum logic [1:0] {
        ADDR_ZERO,
        ADDR_NEXT,
        ADDR_READ
    } addr_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic      load;
        logic      issue;
        addr_sel_t addr_sel;
        logic      capture_hit;
        logic      finish;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       table_empty;
        logic       read_in_range;
        logic       hit;
        logic       last;
        logic       out_free;
    } dp_status_t;

endpackage

@@ hdl/scp_if.sv @@
// Valid/ready channel interfaces for input and result words.
// Depends on scp_pkg for field widths.
interface scp_in_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                cmd;
    logic [scp_pkg::COL_W-1:0] column;
    logic [7:0]                read_index;

    modport source (output valid, cmd, column, read_index, input ready);
    modport sink   (input valid, cmd, column, read_index, output ready);
endinterface

interface scp_out_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  status;
    logic [7:0]                  pattern_index;
    logic                        is_new;
    logic [scp_pkg::CNT16_W-1:0] pattern_count;
    logic [scp_pkg::COL_W-1:0]   pattern_bits;
    logic [8:0]                  distinct_total;
    logic [scp_pkg::CNT16_W-1:0] columns_total;

    modport source (output valid, status, pattern_index, is_new, pattern_count,
                    pattern_bits, distinct_total, columns_total, input ready);
    modport sink   (input valid, status, pattern_index, is_new, pattern_count,
                    pattern_bits, distinct_total, columns_total, output ready);
endinterface

@@ hdl/scp_ctrl.sv @@
// Controller state machine: sequences decode, table scan and result write.
// Depends on scp_pkg for states and the command/status structs.
module scp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  scp_pkg::dp_status_t status,
    output scp_pkg::ctrl_cmd_t  ctrl
);

    scp_pkg::state_t state_reg;
    scp_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= scp_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next       = state_reg;
        in_ready         = 1'b0;
        ctrl.load        = 1'b0;
        ctrl.issue       = 1'b0;
        ctrl.addr_sel    = scp_pkg::ADDR_ZERO;
        ctrl.capture_hit = 1'b0;
        ctrl.finish      = 1'b0;
        case (state_reg)
            scp_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.load  = 1'b1;
                    state_next = scp_pkg::S_DECODE;
                end
            end
            scp_pkg::S_DECODE:
            begin
                state_next = scp_pkg::S_FINISH;
                case (status.cmd)
                    scp_pkg::CMD_INSERT:
                    begin
                        if (!status.table_empty)
                        begin
                            ctrl.issue    = 1'b1;
                            ctrl.addr_sel = scp_pkg::ADDR_ZERO;
                            state_next    = scp_pkg::S_SCAN;
                        end
                    end
                    scp_pkg::CMD_READ:
                    begin
                        if (status.read_in_range)
                        begin
                            ctrl.issue    = 1'b1;
                            ctrl.addr_sel = scp_pkg::ADDR_READ;
                        end
                    end
                    default:
                    begin
                        state_next = scp_pkg::S_FINISH;
                    end
                endcase
            end
            scp_pkg::S_SCAN:
            begin
                // one stored entry compared per cycle, next read in flight
                if (status.hit)
                begin
                    ctrl.capture_hit = 1'b1;
                    state_next       = scp_pkg::S_FINISH;
                end
                else if (status.last)
                begin
                    state_next = scp_pkg::S_FINISH;
                end
                else
                begin
                    ctrl.issue    = 1'b1;
                    ctrl.addr_sel = scp_pkg::ADDR_NEXT;
                end
            end
            scp_pkg::S_FINISH:
            begin
                if (status.out_free)
                begin
                    ctrl.finish = 1'b1;
                    state_next  = scp_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = scp_pkg::S_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/scp_datapath.sv @@
// Datapath: config register, item registers, pattern and count memories,
// match compare, table counters and the result register.
// Depends on scp_pkg for widths, codes and the command/status structs.
module scp_datapath #(
    parameter int MAX_PATTERNS = 256,
    parameter int TAXA_LANES   = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [4:0]                          cfg_wdata,
    input  logic [1:0]                          in_cmd,
    input  logic [scp_pkg::COL_W-1:0]           in_column,
    input  logic [7:0]                          in_read_index,
    input  scp_pkg::ctrl_cmd_t                  ctrl,
    output scp_pkg::dp_status_t                 status,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [1:0]                          out_status,
    output logic [7:0]                          out_pattern_index,
    output logic                                out_is_new,
    output logic [scp_pkg::CNT16_W-1:0]         out_pattern_count,
    output logic [scp_pkg::COL_W-1:0]           out_pattern_bits,
    output logic [8:0]                          out_distinct_total,
    output logic [scp_pkg::CNT16_W-1:0]         out_columns_total
);

    localparam int IDX_W = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
    localparam int CNT_W = $clog2(MAX_PATTERNS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PATTERNS);

    // Pattern memories
    logic [scp_pkg::COL_W-1:0]   store_mem [MAX_PATTERNS];
    logic [scp_pkg::CNT16_W-1:0] count_mem [MAX_PATTERNS];

    logic [4:0]                  num_taxa_reg;
    logic [1:0]                  cmd_reg;
    logic [scp_pkg::COL_W-1:0]   key_reg;
    logic [7:0]                  ridx_reg;
    logic                        hit_reg;
    logic [CNT_W-1:0]            distinct_reg;
    logic [scp_pkg::CNT16_W-1:0] columns_reg;
    logic [scp_pkg::COL_W-1:0]   store_q_reg;
    logic [scp_pkg::CNT16_W-1:0] count_q_reg;
    logic [IDX_W-1:0]            rd_idx_reg;

    logic                        out_valid_reg;
    logic [1:0]                  out_status_reg;
    logic [7:0]                  out_index_reg;
    logic                        out_new_reg;
    logic [scp_pkg::CNT16_W-1:0] out_count_reg;
    logic [scp_pkg::COL_W-1:0]   out_bits_reg;
    logic [8:0]                  out_distinct_reg;
    logic [scp_pkg::CNT16_W-1:0] out_columns_reg;

    logic [4:0]                  lanes;
    logic [scp_pkg::COL_W-1:0]   lane_mask;
    logic [IDX_W+7:0]            ridx_wide;
    logic [IDX_W-1:0]            ridx_idx;
    logic [IDX_W-1:0]            rd_addr;
    logic                        match;
    logic                        read_in_range;
    logic                        table_full;
    logic [scp_pkg::CNT16_W-1:0] count_inc;
    logic [scp_pkg::CNT16_W-1:0] columns_inc;
    logic [CNT_W-1:0]            distinct_next;
    logic [scp_pkg::CNT16_W-1:0] columns_next;
    logic                        mem_we;
    logic                        store_we;
    logic [IDX_W-1:0]            wr_addr;
    logic [scp_pkg::COL_W-1:0]   wr_bits;
    logic [scp_pkg::CNT16_W-1:0] wr_count;
    logic [1:0]                  res_status;
    logic [IDX_W+7:0]            res_index_wide;
    logic                        res_new;
    logic [scp_pkg::CNT16_W-1:0] res_count;
    logic [scp_pkg::COL_W-1:0]   res_bits;
    logic [CNT_W+8:0]            distinct_wide;

    // Lane mask from the taxa count, clamped to 1..TAXA_LANES
    always_comb
    begin
        if (num_taxa_reg == 5'd0)
        begin
            lanes = 5'd1;
        end
        else if (num_taxa_reg > 5'(TAXA_LANES))
        begin
            lanes = 5'(TAXA_LANES);
        end
        else
        begin
            lanes = num_taxa_reg;
        end
        for (int t = 0; t < scp_pkg::LANES_MAX; t++)
        begin
            lane_mask[t*scp_pkg::CODE_W +: scp_pkg::CODE_W] =
                (5'(t) < lanes) ? {scp_pkg::CODE_W{1'b1}} : '0;
        end
    end

    // Index and compare logic
    assign ridx_wide     = {{IDX_W{1'b0}}, ridx_reg};
    assign ridx_idx      = ridx_wide[IDX_W-1:0];
    assign read_in_range = {{CNT_W{1'b0}}, ridx_reg} < {8'd0, distinct_reg};
    assign table_full    = (distinct_reg >= MAX_CNT);
    assign match         = (((store_q_reg ^ key_reg) & lane_mask) == '0);
    assign count_inc     = (count_q_reg == scp_pkg::SAT16) ? count_q_reg
                                                           : count_q_reg + 16'd1;
    assign columns_inc   = (columns_reg == scp_pkg::SAT16) ? columns_reg
                                                           : columns_reg + 16'd1;

    always_comb
    begin
        case (ctrl.addr_sel)
            scp_pkg::ADDR_NEXT: rd_addr = rd_idx_reg + IDX_W'(1);
            scp_pkg::ADDR_READ: rd_addr = ridx_idx;
            default:            rd_addr = '0;
        endcase
    end

    assign status.cmd           = cmd_reg;
    assign status.table_empty   = (distinct_reg == '0);
    assign status.read_in_range = read_in_range;
    assign status.hit           = match;
    assign status.last          = ((CNT_W'(rd_idx_reg) + CNT_W'(1)) == distinct_reg);
    assign status.out_free      = !out_valid_reg || out_ready;

    // Result and table update for the finishing word
    always_comb
    begin
        res_status     = scp_pkg::ST_OK;
        res_index_wide = '0;
        res_new        = 1'b0;
        res_count      = '0;
        res_bits       = '0;
        distinct_next  = distinct_reg;
        columns_next   = columns_reg;
        mem_we         = 1'b0;
        store_we       = 1'b0;
        wr_addr        = rd_idx_reg;
        wr_bits        = key_reg;
        wr_count       = count_inc;
        case (cmd_reg)
            scp_pkg::CMD_INSERT:
            begin
                if (hit_reg)
                begin
                    mem_we         = 1'b1;
                    columns_next   = columns_inc;
                    res_index_wide = {8'd0, rd_idx_reg};
                    res_count      = count_inc;
                    res_bits       = store_q_reg;
                end
                else if (table_full)
                begin
                    res_status = scp_pkg::ST_FULL;
                end
                else
                begin
                    mem_we         = 1'b1;
                    store_we       = 1'b1;
                    wr_addr        = distinct_reg[IDX_W-1:0];
                    wr_count       = 16'd1;
                    distinct_next  = distinct_reg + CNT_W'(1);
                    columns_next   = columns_inc;
                    res_index_wide = {8'd0, distinct_reg[IDX_W-1:0]};
                    res_new        = 1'b1;
                    res_count      = 16'd1;
                    res_bits       = key_reg;
                end
            end
            scp_pkg::CMD_READ:
            begin
                res_index_wide = {{IDX_W{1'b0}}, ridx_reg};
                if (read_in_range)
                begin
                    res_count = count_q_reg;
                    res_bits  = store_q_reg;
                end
                else
                begin
                    res_status = scp_pkg::ST_RANGE;
                end
            end
            scp_pkg::CMD_CLEAR:
            begin
                distinct_next = '0;
                columns_next  = '0;
            end
            default:
            begin
                res_status = scp_pkg::ST_OK;
            end
        endcase
    end

    assign distinct_wide = {9'd0, distinct_next};

    // Memories: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (ctrl.finish && mem_we)
        begin
            count_mem[wr_addr] <= wr_count;
            if (store_we)
            begin
                store_mem[wr_addr] <= wr_bits;
            end
        end
        if (ctrl.issue)
        begin
            store_q_reg <= store_mem[rd_addr];
            count_q_reg <= count_mem[rd_addr];
            rd_idx_reg  <= rd_addr;
        end
    end

    // Item payload registers
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg  <= in_cmd;
            key_reg  <= in_column & lane_mask;
            ridx_reg <= in_read_index;
        end
    end

    // Control and counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_taxa_reg  <= scp_pkg::NUM_TAXA_RESET;
            hit_reg       <= 1'b0;
            distinct_reg  <= '0;
            columns_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                num_taxa_reg <= cfg_wdata;
            end
            if (ctrl.load)
            begin
                hit_reg <= 1'b0;
            end
            else if (ctrl.capture_hit)
            begin
                hit_reg <= 1'b1;
            end
            if (ctrl.finish)
            begin
                distinct_reg  <= distinct_next;
                columns_reg   <= columns_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result word register
    always_ff @(posedge clk)
    begin
        if (ctrl.finish)
        begin
            out_status_reg   <= res_status;
            out_index_reg    <= res_index_wide[7:0];
            out_new_reg      <= res_new;
            out_count_reg    <= res_count;
            out_bits_reg     <= res_bits;
            out_distinct_reg <= distinct_wide[8:0];
            out_columns_reg  <= columns_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign out_status         = out_status_reg;
    assign out_pattern_index  = out_index_reg;
    assign out_is_new         = out_new_reg;
    assign out_pattern_count  = out_count_reg;
    assign out_pattern_bits   = out_bits_reg;
    assign out_distinct_total = out_distinct_reg;
    assign out_columns_total  = out_columns_reg;

endmodule

@@ hdl/site_pattern_compressor_unit.sv @@
// Top level of the site pattern compressor: controller plus datapath.
// Depends on scp_pkg, scp_if, scp_ctrl and scp_datapath.
//
// Takes one command word at a time. An insert compares the column against the
// stored patterns in order, one entry per cycle through the pattern memory's
// registered read port, and stops at the first hit or after the last stored entry
// on a miss. Read, clear and the unused command skip the scan and go from decode
// straight to writing the result. The next word is accepted once the controller
// is back in idle after a result is written. A new word is accepted as soon as
// the previous one is finished, even while its result still waits on the output
// register. In that case the new result is held until the old one drains.
// Pattern memory contents are not cleared after reset or by the clear command.
// Entries beyond the stored count are never shown, so no clearing pass runs.
module site_pattern_compressor_unit #(
    parameter int MAX_PATTERNS = 256,
    parameter int TAXA_LANES   = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    scp_in_if.sink     item,
    scp_out_if.source  result,
    input  logic       cfg_we,
    input  logic [4:0] cfg_wdata
);

    scp_pkg::ctrl_cmd_t  ctrl;
    scp_pkg::dp_status_t status;

    scp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (item.ready),
        .status   (status),
        .ctrl     (ctrl)
    );

    scp_datapath #(
        .MAX_PATTERNS (MAX_PATTERNS),
        .TAXA_LANES   (TAXA_LANES)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_wdata          (cfg_wdata),
        .in_cmd             (item.cmd),
        .in_column          (item.column),
        .in_read_index      (item.read_index),
        .ctrl               (ctrl),
        .status             (status),
        .out_ready          (result.ready),
        .out_valid          (result.valid),
        .out_status         (result.status),
        .out_pattern_index  (result.pattern_index),
        .out_is_new         (result.is_new),
        .out_pattern_count  (result.pattern_count),
        .out_pattern_bits   (result.pattern_bits),
        .out_distinct_total (result.distinct_total),
        .out_columns_total  (result.columns_total)
    );

endmodule

@@ hdl/scp_checker.sv @@
// Port-level checker for the site pattern compressor, bound to the top level.
// Depends on scp_pkg for status codes.
module scp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [7:0]  pattern_index,
    input logic        is_new,
    input logic [15:0] pattern_count,
    input logic [63:0] pattern_bits,
    input logic [8:0]  distinct_total
);

    // One word in flight: no accept in the cycle after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted on consecutive cycles");

    // A new pattern carries count one and a nonzero table size
    a_new_pattern: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_new) |->
            (status == scp_pkg::ST_OK && pattern_count == 16'd1 && distinct_total != 9'd0))
        else $error("new pattern result inconsistent");

    // A dropped column reports an empty entry
    a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == scp_pkg::ST_FULL) |->
            (pattern_index == 8'd0 && !is_new && pattern_count == 16'd0 &&
             pattern_bits == 64'd0))
        else $error("table-full result carries data");

    // An out-of-range read reports no data
    a_range_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == scp_pkg::ST_RANGE) |->
            (!is_new && pattern_count == 16'd0 && pattern_bits == 64'd0))
        else $error("out-of-range read carries data");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(pattern_bits) &&
                                       $stable(status)))
        else $error("stalled result changed");

endmodule

bind site_pattern_compressor_unit scp_checker u_scp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (item.valid),
    .in_ready       (item.ready),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .status         (result.status),
    .pattern_index  (result.pattern_index),
    .is_new         (result.is_new),
    .pattern_count  (result.pattern_count),
    .pattern_bits   (result.pattern_bits),
    .distinct_total (result.distinct_total)
);

@@ bench/site_pattern_compressor_unit_test.sv @@
// Self-checking bench for site_pattern_compressor_unit: column inserts, reads and clears
// are checked word by word against a pattern-table predictor kept in the bench.
// Depends on scp_pkg, scp_if and the RTL of the compressor.
module site_pattern_compressor_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         MAX_PAT     = 256;
    localparam int         LANES       = 16;
    localparam int         CYCLE_LIMIT = 3_000_000;
    localparam int         DRAIN_WAIT  = 300;
    localparam int         ERR_PRINTS  = 40;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;

    typedef struct packed {
        logic [1:0]                cmd;
        logic [scp_pkg::COL_W-1:0] column;
        logic [7:0]                read_index;
    } column_word_t;

    typedef struct packed {
        logic [1:0]                  status;
        logic [7:0]                  pattern_index;
        logic                        is_new;
        logic [scp_pkg::CNT16_W-1:0] pattern_count;
        logic [scp_pkg::COL_W-1:0]   pattern_bits;
        logic [8:0]                  distinct_total;
        logic [scp_pkg::CNT16_W-1:0] columns_total;
    } pattern_result_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [4:0] cfg_wdata;

    scp_in_if  in_ch ();
    scp_out_if out_ch ();

    site_pattern_compressor_unit #(
        .MAX_PATTERNS (MAX_PAT),
        .TAXA_LANES   (LANES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (in_ch),
        .result    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Predicted table contents and register copy
    logic [scp_pkg::COL_W-1:0]   tbl_bits  [MAX_PAT];
    logic [scp_pkg::CNT16_W-1:0] tbl_count [MAX_PAT];
    int                          tbl_distinct;
    logic [scp_pkg::CNT16_W-1:0] tbl_columns;
    logic [4:0]                  taxa_setting;

    column_word_t              pending_words[$];
    pattern_result_t           expected_results[$];
    pattern_result_t           front_result;
    column_word_t              next_word;
    logic [scp_pkg::COL_W-1:0] col_pool[$];

    int send_idle_pct;
    int recv_idle_pct;
    int n_errors;
    int n_results;
    int n_inserts, n_new, n_full, n_reads, n_range, n_clears, n_unused;
    int cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int eff_lanes(input logic [4:0] n);
        if (n == 5'd0)
            return 1;
        if (n > LANES)
            return LANES;
        return int'(n);
    endfunction

    function automatic logic [scp_pkg::COL_W-1:0] lane_mask_of(input logic [4:0] n);
        int lanes;
        lanes = eff_lanes(n);
        if (lanes >= 16)
            return '1;
        return (64'd1 << (4 * lanes)) - 64'd1;
    endfunction

    function automatic logic [scp_pkg::COL_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Pattern table predictor: one accepted word in, one result word out
    function automatic pattern_result_t compress_word(input column_word_t w);
        pattern_result_t           r;
        logic [scp_pkg::COL_W-1:0] m;
        logic [scp_pkg::COL_W-1:0] key;
        int                        k;
        int                        hit_at;
        r = '0;
        case (w.cmd)
            scp_pkg::CMD_INSERT:
            begin
                n_inserts++;
                m = lane_mask_of(taxa_setting);
                key = w.column & m;
                hit_at = -1;
                for (k = 0; k < tbl_distinct; k++)
                    if (hit_at < 0 && ((tbl_bits[k] ^ key) & m) == '0)
                        hit_at = k;
                if (hit_at >= 0)
                begin
                    if (tbl_count[hit_at] != scp_pkg::SAT16)
                        tbl_count[hit_at]++;
                    if (tbl_columns != scp_pkg::SAT16)
                        tbl_columns++;
                    r.pattern_index = hit_at[7:0];
                    r.pattern_count = tbl_count[hit_at];
                    r.pattern_bits  = tbl_bits[hit_at];
                end
                else if (tbl_distinct >= MAX_PAT)
                begin
                    // table full: column dropped, not counted
                    r.status = scp_pkg::ST_FULL;
                    n_full++;
                end
                else
                begin
                    tbl_bits[tbl_distinct]  = key;
                    tbl_count[tbl_distinct] = 16'd1;
                    r.pattern_index = tbl_distinct[7:0];
                    r.is_new        = 1'b1;
                    r.pattern_count = 16'd1;
                    r.pattern_bits  = key;
                    tbl_distinct++;
                    if (tbl_columns != scp_pkg::SAT16)
                        tbl_columns++;
                    n_new++;
                end
            end
            scp_pkg::CMD_READ:
            begin
                n_reads++;
                r.pattern_index = w.read_index;
                if (int'(w.read_index) >= tbl_distinct)
                begin
                    r.status = scp_pkg::ST_RANGE;
                    n_range++;
                end
                else
                begin
                    r.pattern_count = tbl_count[w.read_index];
                    r.pattern_bits  = tbl_bits[w.read_index];
                end
            end
            scp_pkg::CMD_CLEAR:
            begin
                n_clears++;
                tbl_distinct = 0;
                tbl_columns  = '0;
            end
            default:
                n_unused++;
        endcase
        r.distinct_total = tbl_distinct[8:0];
        r.columns_total  = tbl_columns;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want)
        begin
            n_errors++;
            if (n_errors <= ERR_PRINTS)
                $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
        end
    endfunction

    // Driver: presents queued words, predicts each one as it is accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid      <= 1'b0;
            in_ch.cmd        <= scp_pkg::CMD_INSERT;
            in_ch.column     <= '0;
            in_ch.read_index <= '0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                expected_results = {expected_results, compress_word(
                    column_word_t'{in_ch.cmd, in_ch.column, in_ch.read_index})};
            if (!in_ch.valid || in_ch.ready)
            begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_word = pending_words.pop_front();
                    in_ch.valid      <= 1'b1;
                    in_ch.cmd        <= next_word.cmd;
                    in_ch.column     <= next_word.column;
                    in_ch.read_index <= next_word.read_index;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: random back-pressure, compares each result word in order
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            if (out_ch.valid && out_ch.ready)
            begin
                n_results++;
                if (expected_results.size() == 0)
                begin
                    n_errors++;
                    if (n_errors <= ERR_PRINTS)
                        $error("result word arrived with nothing expected");
                end
                else
                begin
                    front_result = expected_results.pop_front();
                    check_field("status", 64'(front_result.status), 64'(out_ch.status));
                    check_field("pattern_index", 64'(front_result.pattern_index),
                                64'(out_ch.pattern_index));
                    check_field("is_new", 64'(front_result.is_new), 64'(out_ch.is_new));
                    check_field("pattern_count", 64'(front_result.pattern_count),
                                64'(out_ch.pattern_count));
                    check_field("pattern_bits", front_result.pattern_bits,
                                out_ch.pattern_bits);
                    check_field("distinct_total", 64'(front_result.distinct_total),
                                64'(out_ch.distinct_total));
                    check_field("columns_total", 64'(front_result.columns_total),
                                64'(out_ch.columns_total));
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Queue a word, keeping the backlog short
    task automatic push_word(input logic [1:0] cmd, input logic [scp_pkg::COL_W-1:0] col,
                             input logic [7:0] idx);
        column_word_t w;
        while (pending_words.size() >= 16)
            @(negedge clk);
        w.cmd        = cmd;
        w.column     = col;
        w.read_index = idx;
        pending_words = {pending_words, w};
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_words.size() != 0 || in_ch.valid || expected_results.size() != 0);
    endtask

    // Register write, only called with the block idle
    task automatic write_taxa(input logic [4:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        taxa_setting = value;
        @(negedge clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // Mostly inserts drawn from a pool of recent columns, so hits dominate
    task automatic random_traffic(input int n_words);
        logic [scp_pkg::COL_W-1:0] m;
        logic [scp_pkg::COL_W-1:0] col;
        int                        r;
        m = lane_mask_of(taxa_setting);
        repeat (n_words)
        begin
            r = $urandom_range(99);
            if (r < 55 && col_pool.size() != 0)
            begin
                // known column, noise in the lanes that are not compared
                col = col_pool[$urandom_range(col_pool.size() - 1)];
                col = (col & m) | (rand64() & ~m);
                push_word(scp_pkg::CMD_INSERT, col, 8'($urandom));
            end
            else if (r < 78)
            begin
                col = rand64();
                if (col_pool.size() >= 24)
                    col_pool.delete(0);
                col_pool = {col_pool, col};
                push_word(scp_pkg::CMD_INSERT, col, 8'($urandom));
            end
            else if (r < 90)
            begin
                if ($urandom_range(99) < 70)
                    push_word(scp_pkg::CMD_READ, rand64(), 8'($urandom_range(31)));
                else
                    push_word(scp_pkg::CMD_READ, rand64(), 8'($urandom_range(255)));
            end
            else if (r < 94)
            begin
                push_word(scp_pkg::CMD_CLEAR, rand64(), 8'($urandom));
                if ($urandom_range(1) == 0)
                    col_pool.delete();
            end
            else if (r < 97)
                push_word(CMD_UNUSED, rand64(), 8'($urandom));
            else if (col_pool.size() != 0)
            begin
                // near miss: one compared bit flipped
                col = col_pool[$urandom_range(col_pool.size() - 1)];
                col[$urandom_range(4 * eff_lanes(taxa_setting) - 1)] ^= 1'b1;
                push_word(scp_pkg::CMD_INSERT, col, 8'($urandom));
            end
            else
                push_word(scp_pkg::CMD_INSERT, '0, 8'($urandom));
        end
    endtask

    // Main sequence
    initial
    begin
        logic [scp_pkg::COL_W-1:0] keep_col;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        tbl_distinct     = 0;
        tbl_columns      = '0;
        taxa_setting     = scp_pkg::NUM_TAXA_RESET;
        n_errors = 0;
        n_results = 0;
        n_inserts = 0; n_new = 0; n_full = 0;
        n_reads = 0; n_range = 0; n_clears = 0; n_unused = 0;
        set_idling(36, 60);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed words at the reset setting of 16 taxa
        push_word(scp_pkg::CMD_READ, '0, 8'd0);
        push_word(scp_pkg::CMD_READ, '1, 8'd255);
        push_word(scp_pkg::CMD_INSERT, '1, 8'd0);
        push_word(scp_pkg::CMD_INSERT, '0, 8'd255);
        push_word(scp_pkg::CMD_INSERT, '1, 8'd0);
        push_word(scp_pkg::CMD_INSERT, 64'hA5A5_5A5A_0F0F_F0F0, 8'd0);
        push_word(scp_pkg::CMD_INSERT, 64'h8000_0000_0000_0000, 8'd0);
        push_word(scp_pkg::CMD_INSERT, 64'h0000_0000_0000_0001, 8'd0);
        push_word(scp_pkg::CMD_INSERT, 64'h8000_0000_0000_0000, 8'd0);
        push_word(scp_pkg::CMD_READ, '0, 8'd0);
        push_word(scp_pkg::CMD_READ, '0, 8'd4);
        push_word(scp_pkg::CMD_READ, '0, 8'd5);
        push_word(CMD_UNUSED, '1, 8'd255);
        push_word(scp_pkg::CMD_CLEAR, '1, 8'd255);
        push_word(scp_pkg::CMD_READ, '0, 8'd0);
        push_word(scp_pkg::CMD_INSERT, 64'h5555_5555_5555_5555, 8'd0);
        push_word(scp_pkg::CMD_INSERT, 64'h5555_5555_5555_5555, 8'd0);
        push_word(CMD_UNUSED, 64'h1234_5678_9ABC_DEF0, 8'd17);
        random_traffic(300);

        // One taxon: upper lanes ignored and stored as zero
        wait_drained();
        write_taxa(5'd1);
        push_word(scp_pkg::CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFF3, 8'd0);
        push_word(scp_pkg::CMD_INSERT, 64'h0000_0000_0000_0003, 8'd0);
        push_word(scp_pkg::CMD_READ, '0, 8'd0);
        push_word(scp_pkg::CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFF4, 8'd0);
        random_traffic(300);

        // Zero taxa behaves as one; table kept from the previous setting
        wait_drained();
        write_taxa(5'd0);
        push_word(scp_pkg::CMD_INSERT, 64'hABCD_EF01_2345_6783, 8'd0);
        random_traffic(150);

        set_idling(60, 36);
        wait_drained();
        write_taxa(5'd31);
        push_word(scp_pkg::CMD_INSERT, '1, 8'd0);
        random_traffic(300);

        wait_drained();
        write_taxa(5'd7);
        random_traffic(300);

        // Fill the table, then drop columns that miss
        push_word(scp_pkg::CMD_CLEAR, '0, 8'd0);
        keep_col = '0;
        for (int k = 0; k < MAX_PAT; k++)
        begin
            keep_col = (rand64() << 8) | 64'(k);
            push_word(scp_pkg::CMD_INSERT, keep_col, 8'd0);
        end
        repeat (3)
            push_word(scp_pkg::CMD_INSERT, rand64(), 8'd0);
        push_word(scp_pkg::CMD_INSERT, keep_col, 8'd0);
        push_word(scp_pkg::CMD_READ, '0, 8'd255);
        push_word(scp_pkg::CMD_READ, '0, 8'd128);
        push_word(scp_pkg::CMD_CLEAR, '0, 8'd0);

        set_idling(0, 0);
        wait_drained();
        write_taxa(5'd16);
        random_traffic(100);

        wait_drained();
        write_taxa(5'd10);
        random_traffic(100);

        // One pattern hit repeatedly, noise above the compared lanes
        push_word(scp_pkg::CMD_CLEAR, '0, 8'd0);
        keep_col = rand64();
        repeat (40)
            push_word(scp_pkg::CMD_INSERT,
                      (keep_col & lane_mask_of(5'd10)) | (rand64() << 40), 8'd0);
        push_word(scp_pkg::CMD_READ, '0, 8'd0);
        push_word(scp_pkg::CMD_INSERT, ~keep_col, 8'd0);
        push_word(scp_pkg::CMD_READ, '0, 8'd1);
        push_word(scp_pkg::CMD_CLEAR, '0, 8'd0);

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Run covered %0d words, %0d results: %0d inserts (%0d new, %0d dropped full),",
                 n_inserts + n_reads + n_clears + n_unused, n_results, n_inserts, n_new, n_full);
        $display("  %0d reads (%0d out of range), %0d clears, %0d unused commands, %0d errors",
                 n_reads, n_range, n_clears, n_unused, n_errors);
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ files.f @@
hdl/scp_pkg.sv
hdl/scp_if.sv
hdl/scp_ctrl.sv
hdl/scp_datapath.sv
hdl/site_pattern_compressor_unit.sv
hdl/scp_checker.sv
bench/site_pattern_compressor_unit_test.sv
